// ----- design/apl_pkg.sv -----
// shared types, codes and constants for the pointer layer controller
`default_nettype none

package apl_pkg;

    localparam int LAYER_COUNT    = 32;
    localparam int LAYER_BITS     = 5;
    localparam int EXCLUDED_SLOTS = 4;
    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_INDEX_BITS = 3;

    // input commands
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_MOTION    = 3'd1;
    localparam logic [2:0] CMD_POS_PRESS = 3'd2;
    localparam logic [2:0] CMD_KEY_PRESS = 3'd3;
    localparam logic [2:0] CMD_LAYER_OFF = 3'd4;

    // change codes
    localparam logic [1:0] CHG_NONE = 2'd0;
    localparam logic [1:0] CHG_ON   = 2'd1;
    localparam logic [1:0] CHG_OFF  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IDLE_MS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXCL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXCL_POS_A = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXCL_POS_B = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXCL_POS_C = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXCL_POS_D = 3'd6;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  position;
        logic [7:0]  layer_req;
        logic [15:0] timeout_ms;
    } apl_in_t;

    typedef struct packed {
        logic                  layer_on;
        logic [LAYER_BITS-1:0] layer_out;
        logic [1:0]            change;
        logic                  bad_layer;
    } apl_out_t;

endpackage

`default_nettype wire

// ----- design/apl_engine.sv -----
// configuration registers, layer state and the per-beat update logic
`default_nettype none

module apl_engine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [apl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [apl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  wire logic                                 step_en,
    input  wire apl_pkg::apl_in_t                     item,
    output apl_pkg::apl_out_t                         result
);

    logic        enabled_reg;
    logic [14:0] idle_ms_reg;
    logic [2:0]  excl_count_reg;
    logic [7:0]  excl_pos_reg [apl_pkg::EXCLUDED_SLOTS];

    logic [31:0]                     now_reg, now_next;
    logic [31:0]                     last_key_reg, last_key_next;
    logic                            active_reg, active_next;
    logic [apl_pkg::LAYER_BITS-1:0]  layer_reg, layer_next;
    logic [15:0]                     countdown_reg, countdown_next;
    logic                            running_reg, running_next;

    logic [31:0] elapsed;
    logic [2:0]  excl_used;
    logic        excluded;
    logic        bad;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b1;
            idle_ms_reg    <= '0;
            excl_count_reg <= '0;
            for (int i = 0; i < apl_pkg::EXCLUDED_SLOTS; i++) begin
                excl_pos_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                apl_pkg::REG_ENABLED:    enabled_reg     <= cfg_wdata[0];
                apl_pkg::REG_IDLE_MS:    idle_ms_reg     <= cfg_wdata[14:0];
                apl_pkg::REG_EXCL_COUNT: excl_count_reg  <= cfg_wdata[2:0];
                apl_pkg::REG_EXCL_POS_A: excl_pos_reg[0] <= cfg_wdata[7:0];
                apl_pkg::REG_EXCL_POS_B: excl_pos_reg[1] <= cfg_wdata[7:0];
                apl_pkg::REG_EXCL_POS_C: excl_pos_reg[2] <= cfg_wdata[7:0];
                apl_pkg::REG_EXCL_POS_D: excl_pos_reg[3] <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign elapsed   = now_reg - last_key_reg;
    assign excl_used = (excl_count_reg > 3'(apl_pkg::EXCLUDED_SLOTS))
                     ? 3'(apl_pkg::EXCLUDED_SLOTS) : excl_count_reg;

    always_comb begin
        excluded = 1'b0;
        for (int i = 0; i < apl_pkg::EXCLUDED_SLOTS; i++) begin
            if ((3'(i) < excl_used) && (excl_pos_reg[i] == item.position)) begin
                excluded = 1'b1;
            end
        end
    end

    always_comb begin
        now_next       = now_reg;
        last_key_next  = last_key_reg;
        active_next    = active_reg;
        layer_next     = layer_reg;
        countdown_next = countdown_reg;
        running_next   = running_reg;
        bad            = 1'b0;

        // a disabled block drops the layer before the command is handled
        if (!enabled_reg && active_reg) begin
            active_next    = 1'b0;
            running_next   = 1'b0;
            countdown_next = '0;
        end

        unique case (item.command)
            apl_pkg::CMD_TICK: begin
                now_next = now_reg + 32'd1;
                if (running_next) begin
                    countdown_next = countdown_next - 16'd1;
                    if (countdown_next == '0) begin
                        running_next = 1'b0;
                        active_next  = 1'b0;
                    end
                end
            end
            apl_pkg::CMD_MOTION: begin
                if (item.layer_req >= 8'(apl_pkg::LAYER_COUNT)) begin
                    bad = 1'b1;
                end else if (enabled_reg) begin
                    layer_next = item.layer_req[apl_pkg::LAYER_BITS-1:0];
                    if (!active_next && (elapsed >= {17'd0, idle_ms_reg})) begin
                        active_next = 1'b1;
                    end
                    if (item.timeout_ms != '0) begin
                        countdown_next = item.timeout_ms;
                        running_next   = 1'b1;
                    end
                end
            end
            apl_pkg::CMD_POS_PRESS: begin
                if (active_next && (excl_count_reg != '0) && !excluded) begin
                    active_next = 1'b0;
                end
            end
            apl_pkg::CMD_KEY_PRESS: begin
                last_key_next = now_reg;
            end
            apl_pkg::CMD_LAYER_OFF: begin
                active_next    = 1'b0;
                running_next   = 1'b0;
                countdown_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg       <= '0;
            last_key_reg  <= '0;
            active_reg    <= 1'b0;
            layer_reg     <= '0;
            countdown_reg <= '0;
            running_reg   <= 1'b0;
        end else if (step_en) begin
            now_reg       <= now_next;
            last_key_reg  <= last_key_next;
            active_reg    <= active_next;
            layer_reg     <= layer_next;
            countdown_reg <= countdown_next;
            running_reg   <= running_next;
        end
    end

    always_comb begin
        result.layer_on  = active_next;
        result.layer_out = layer_next;
        result.bad_layer = bad;
        if (active_next == active_reg) begin
            result.change = apl_pkg::CHG_NONE;
        end else if (active_next) begin
            result.change = apl_pkg::CHG_ON;
        end else begin
            result.change = apl_pkg::CHG_OFF;
        end
    end

endmodule

`default_nettype wire

// ----- design/auto_pointer_layer_controller.sv -----
// top level of the automatic pointer layer controller
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_data  (apl_in_t)
//   m_       out        m_valid / m_ready  m_data  (apl_out_t)
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// one result beat per input beat; an input beat is registered, then
// evaluated combinationally against the layer state and the result registered,
// so one beat can be taken every cycle unless the output register holds the pipe.
// the output register only holds the pipe while m_ready is low.
// aresetn is synchronous; it clears the pipe and returns the layer state and
// the configuration registers to their reset values.
`default_nettype none

module auto_pointer_layer_controller (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire apl_pkg::apl_in_t                     s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output apl_pkg::apl_out_t                         m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [apl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [apl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    apl_pkg::apl_in_t  in_reg;
    logic              in_valid_reg;
    apl_pkg::apl_out_t out_reg;
    logic              out_valid_reg;
    apl_pkg::apl_out_t step_result;
    logic              advance;

    // input stage moves on when the output slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    apl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .item      (in_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
